### sv/mic_pkg.sv
package mic_pkg;

  localparam int unsigned LATENCY   = 28;
  localparam int unsigned SQRT_STEPS = 24;
  localparam int unsigned COS_STEPS  = 6;

  localparam logic [18:0] PI_Q16     = 19'd205887;
  localparam logic [18:0] TWO_PI_Q16 = 19'd411775;
  localparam logic [30:0] COS_ONE    = 31'h4000_0000;

  // taylor divisors and their reciprocals scaled by 2^36
  localparam logic [7:0] SERIES_DIV [COS_STEPS] = '{
    8'd132, 8'd90, 8'd56, 8'd30, 8'd12, 8'd2
  };
  localparam logic [35:0] SERIES_RECIP [COS_STEPS] = '{
    36'd520602096, 36'd763549741, 36'd1227133513,
    36'd2290649224, 36'd5726623061, 36'd34359738368
  };

  typedef struct packed {
    logic        mode;
    logic        bad;
    logic [48:0] masses;
    logic [48:0] energies;
  } side_t;

endpackage

### sv/mandelstam_invariant_calc.sv
// Mandelstam t/s invariant for a two-body event.
// Command channel: an event is taken at a rising edge with start_i high and
// busy_o low. busy_o is always low, so one event can be given every cycle.
// Result channel: done_o is high for exactly one cycle with invariant_o,
// momentum_a_o, momentum_b_o and unphysical_o; the receiver cannot stall.
// Throughput is one event per cycle. The pipeline is made of the two
// 24-step square root pipelines for the momenta, one result bit per stage,
// in parallel with a six-term cosine series that takes three stages per
// term, followed by the momentum product (two multiply stages) and the
// final sum and saturation.
// An energy below its mass gives a momentum of zero and raises unphysical_o.
// Reset clears the valid bits only; events in flight at reset are dropped.
module mandelstam_invariant_calc
  import mic_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic               mode_i,
  input  logic        [23:0] mass_a_i,
  input  logic        [23:0] mass_b_i,
  input  logic        [23:0] energy_a_i,
  input  logic        [23:0] energy_b_i,
  input  logic signed [18:0] angle_i,
  output logic               done_o,
  output logic signed [50:0] invariant_o,
  output logic        [23:0] momentum_a_o,
  output logic        [23:0] momentum_b_o,
  output logic               unphysical_o
);

  logic [LATENCY-1:0] valid_q;

  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[LATENCY-2:0], start_i & ~busy_o};
    end
  end

  // stage 1: squares and angle fold
  logic [47:0] ma2, mb2, ea2, eb2, eab;
  logic        bad_a, bad_b;
  logic [18:0] ang_u, mag, f1;
  logic [16:0] f2;
  logic        fneg;
  side_t       side_d;
  logic [47:0] diff_a_q, diff_b_q;
  logic [16:0] fold_q;
  logic        fneg_q;
  side_t       side_q [SQRT_STEPS+1];

  always_comb begin
    ma2   = 48'(mass_a_i) * 48'(mass_a_i);
    mb2   = 48'(mass_b_i) * 48'(mass_b_i);
    ea2   = 48'(energy_a_i) * 48'(energy_a_i);
    eb2   = 48'(energy_b_i) * 48'(energy_b_i);
    eab   = 48'(energy_a_i) * 48'(energy_b_i);
    bad_a = energy_a_i < mass_a_i;
    bad_b = energy_b_i < mass_b_i;
    side_d.mode     = mode_i;
    side_d.bad      = bad_a | bad_b;
    side_d.masses   = {1'b0, ma2} + {1'b0, mb2};
    side_d.energies = {eab, 1'b0};
    ang_u = angle_i;
    mag   = angle_i[18] ? (~ang_u + 19'd1) : ang_u;
    f1    = (mag > PI_Q16) ? (TWO_PI_Q16 - mag) : mag;
    fneg  = {f1, 1'b0} > {1'b0, PI_Q16};
    f2    = fneg ? 17'(PI_Q16 - f1) : f1[16:0];
  end

  always_ff @(posedge clk_i) begin
    diff_a_q  <= bad_a ? '0 : ea2 - ma2;
    diff_b_q  <= bad_b ? '0 : eb2 - mb2;
    fold_q    <= f2;
    fneg_q    <= fneg;
    side_q[0] <= side_d;
    for (int k = 1; k <= SQRT_STEPS; k++) begin
      side_q[k] <= side_q[k-1];
    end
  end

  // stages 2..25: square roots, one result bit per stage
  logic [47:0] rem_a_q [SQRT_STEPS];
  logic [47:0] res_a_q [SQRT_STEPS];
  logic [47:0] rem_b_q [SQRT_STEPS];
  logic [47:0] res_b_q [SQRT_STEPS];

  for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sqrt
    localparam logic [47:0] BIT = 48'd1 << (46 - 2 * i);
    logic [47:0] ra, rb, sa, sb, ca, cb;
    always_comb begin
      ra = (i == 0) ? diff_a_q : rem_a_q[(i == 0) ? 0 : i-1];
      rb = (i == 0) ? diff_b_q : rem_b_q[(i == 0) ? 0 : i-1];
      sa = (i == 0) ? '0 : res_a_q[(i == 0) ? 0 : i-1];
      sb = (i == 0) ? '0 : res_b_q[(i == 0) ? 0 : i-1];
      ca = sa + BIT;
      cb = sb + BIT;
    end
    always_ff @(posedge clk_i) begin
      if (ra >= ca) begin
        rem_a_q[i] <= ra - ca;
        res_a_q[i] <= (sa >> 1) + BIT;
      end else begin
        rem_a_q[i] <= ra;
        res_a_q[i] <= sa >> 1;
      end
      if (rb >= cb) begin
        rem_b_q[i] <= rb - cb;
        res_b_q[i] <= (sb >> 1) + BIT;
      end else begin
        rem_b_q[i] <= rb;
        res_b_q[i] <= sb >> 1;
      end
    end
  end

  // stage 2: angle squared, then three stages per series term
  logic [31:0] x2_q  [COS_STEPS+1];
  logic [30:0] t_q   [COS_STEPS+1];
  logic        neg_q [COS_STEPS+1];
  logic [31:0] v_q   [COS_STEPS];
  logic [31:0] xa_q  [COS_STEPS];
  logic        na_q  [COS_STEPS];
  logic [31:0] q0_q  [COS_STEPS];
  logic [31:0] vb_q  [COS_STEPS];
  logic [31:0] xb_q  [COS_STEPS];
  logic        nb_q  [COS_STEPS];
  logic [33:0] fold_sq;

  assign fold_sq = 34'(fold_q) * 34'(fold_q);

  always_ff @(posedge clk_i) begin
    x2_q[0]  <= fold_sq[33:2];
    t_q[0]   <= COS_ONE;
    neg_q[0] <= fneg_q;
  end

  for (genvar i = 0; i < COS_STEPS; i++) begin : g_cos
    logic [62:0] p;
    logic [67:0] m;
    logic [39:0] qd, r;
    logic        ge;
    logic [32:0] sub;
    always_comb begin
      p   = 63'(x2_q[i]) * 63'(t_q[i]);
      m   = 68'(v_q[i]) * 68'(SERIES_RECIP[i]);
      qd  = 40'(q0_q[i]) * 40'(SERIES_DIV[i]);
      r   = 40'(vb_q[i]) - qd;
      ge  = r >= 40'(SERIES_DIV[i]);
      sub = 33'(q0_q[i]) + 33'(ge);
    end
    always_ff @(posedge clk_i) begin
      v_q[i]    <= p[61:30];
      xa_q[i]   <= x2_q[i];
      na_q[i]   <= neg_q[i];
      q0_q[i]   <= m[67:36];
      vb_q[i]   <= v_q[i];
      xb_q[i]   <= xa_q[i];
      nb_q[i]   <= na_q[i];
      t_q[i+1]  <= (sub > 33'(COS_ONE)) ? '0 : 31'(33'(COS_ONE) - sub);
      x2_q[i+1] <= xb_q[i];
      neg_q[i+1] <= nb_q[i];
    end
  end

  // stage 21: round to q1.16, then delay to stage 25
  logic [30:0] t_rnd;
  logic [16:0] c_q  [5];
  logic        cn_q [5];

  assign t_rnd = t_q[COS_STEPS] + 31'h2000;

  always_ff @(posedge clk_i) begin
    c_q[0]  <= t_rnd[30:14];
    cn_q[0] <= neg_q[COS_STEPS];
    for (int k = 1; k < 5; k++) begin
      c_q[k]  <= c_q[k-1];
      cn_q[k] <= cn_q[k-1];
    end
  end

  // stage 26: momentum product
  logic [47:0] pp_q;
  logic [16:0] c26_q;
  logic        n26_q, n27_q;
  side_t       s26_q, s27_q;
  logic [23:0] pa26_q, pb26_q, pa27_q, pb27_q;

  always_ff @(posedge clk_i) begin
    pp_q   <= 48'(res_a_q[SQRT_STEPS-1][23:0]) * 48'(res_b_q[SQRT_STEPS-1][23:0]);
    c26_q  <= c_q[4];
    n26_q  <= cn_q[4];
    s26_q  <= side_q[SQRT_STEPS];
    pa26_q <= res_a_q[SQRT_STEPS-1][23:0];
    pb26_q <= res_b_q[SQRT_STEPS-1][23:0];
  end

  // stage 27: scale by cosine
  logic [64:0] pc;
  logic [48:0] prod_q;

  assign pc = 65'(pp_q) * 65'(c26_q) + 65'h8000;

  always_ff @(posedge clk_i) begin
    prod_q <= pc[64:16];
    n27_q  <= n26_q;
    s27_q  <= s26_q;
    pa27_q <= pa26_q;
    pb27_q <= pb26_q;
  end

  // stage 28: sum and saturate
  logic signed [52:0] mom, masses, energies, inv;

  always_comb begin
    mom      = $signed({3'b0, prod_q, 1'b0});
    if (n27_q) mom = -mom;
    masses   = $signed({4'b0, s27_q.masses});
    energies = $signed({4'b0, s27_q.energies});
    if (s27_q.mode) begin
      inv = masses + energies - mom;
    end else begin
      inv = masses - energies + mom;
    end
  end

  always_ff @(posedge clk_i) begin
    if (inv > $signed(53'h3_FFFF_FFFF_FFFF)) begin
      invariant_o <= 51'h3_FFFF_FFFF_FFFF;
    end else if (inv < -$signed(53'h4_0000_0000_0000)) begin
      invariant_o <= 51'h4_0000_0000_0000;
    end else begin
      invariant_o <= inv[50:0];
    end
    momentum_a_o <= pa27_q;
    momentum_b_o <= pb27_q;
    unphysical_o <= s27_q.bad;
  end

  assign done_o = valid_q[LATENCY-1];

endmodule
